// File: hw/rtl/sip_pkg.sv
// Package for the segment intersection point block.
// Holds hit codes, register indexes and default widths; no dependencies.
package sip_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int PT_TOL_W       = 8;
	localparam int COL_TOL_W      = 16;
	localparam int CFG_DATA_W     = 16;
	localparam int CFG_INDEX_W    = 1;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_CROSS = 2'd1,
		KIND_A_PT  = 2'd2,
		KIND_B_PT  = 2'd3
	} hit_kind_t;

	localparam logic [CFG_INDEX_W-1:0] REG_POINT_TOL = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COL_TOL   = 1'd1;

endpackage

// File: hw/rtl/sip_in_if.sv
// Input channel carrying one segment pair per transaction.
// Depends on nothing; width set by parameter CW.
interface sip_in_if #(parameter int CW = 16);
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] a_start_x;
	logic signed [CW-1:0] a_start_y;
	logic signed [CW-1:0] a_end_x;
	logic signed [CW-1:0] a_end_y;
	logic signed [CW-1:0] b_start_x;
	logic signed [CW-1:0] b_start_y;
	logic signed [CW-1:0] b_end_x;
	logic signed [CW-1:0] b_end_y;

	modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
		b_start_x, b_start_y, b_end_x, b_end_y, input ready);
	modport sink (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
		b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

// File: hw/rtl/sip_out_if.sv
// Output channel carrying one intersection result per transaction.
// Depends on nothing; width set by parameter CW.
interface sip_out_if #(parameter int CW = 16);
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic [1:0]           hit_kind;
	logic signed [CW-1:0] hit_x;
	logic signed [CW-1:0] hit_y;

	modport source (output valid, hit, hit_kind, hit_x, hit_y, input ready);
	modport sink (input valid, hit, hit_kind, hit_x, hit_y, output ready);
endinterface

// File: hw/rtl/sip_front.sv
// Front pipeline: differences, products, sums, classification, numerators.
// Five register stages; depends on sip_pkg.
module sip_front
	import sip_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [PT_TOL_W-1:0]           point_tol,
	input  logic [COL_TOL_W-1:0]          col_tol,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_BITS-1:0]  x1,
	input  logic signed [COORD_BITS-1:0]  y1,
	input  logic signed [COORD_BITS-1:0]  x2,
	input  logic signed [COORD_BITS-1:0]  y2,
	input  logic signed [COORD_BITS-1:0]  x3,
	input  logic signed [COORD_BITS-1:0]  y3,
	input  logic signed [COORD_BITS-1:0]  x4,
	input  logic signed [COORD_BITS-1:0]  y4,
	output logic                          dn_valid,
	input  logic                          dn_ready,
	output hit_kind_t                     dn_kind,
	output logic signed [COORD_BITS-1:0]  dn_px,
	output logic signed [COORD_BITS-1:0]  dn_py,
	output logic [2*COORD_BITS+1:0]       dn_den,
	output logic [3*COORD_BITS+2:0]       dn_nx,
	output logic [3*COORD_BITS+2:0]       dn_ny,
	output logic                          dn_negx,
	output logic                          dn_negy
);
	localparam int C  = COORD_BITS;
	localparam int DF = C + 1;
	localparam int PW = 2 * C + 2;
	localparam int SW = 2 * C + 3;
	localparam int CP = 2 * C;
	localparam int CS = 2 * C + 1;
	localparam int NP = 3 * C + 2;
	localparam int NW = 3 * C + 3;
	localparam int DW = 2 * C + 2;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	assign en5      = !v_s5 || dn_ready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// stage 1: differences and point tests
	logic signed [DF-1:0] pt_s;
	logic signed [DF-1:0] ab_dx, ab_dy, bb_dx, bb_dy, q13x, q13y, q31x, q31y;
	logic signed [DF-1:0] a12x, a12y, b34x, b34y;
	logic signed [DF-1:0] ab_dx_s1, ab_dy_s1, bb_dx_s1, bb_dy_s1;
	logic signed [DF-1:0] q13x_s1, q13y_s1, q31x_s1, q31y_s1;
	logic signed [DF-1:0] a12x_s1, a12y_s1, b34x_s1, b34y_s1;
	logic signed [C-1:0]  x1_s1, y1_s1, x2_s1, y2_s1, x3_s1, y3_s1, x4_s1, y4_s1;
	logic                 apt_s1, bpt_s1, close_s1;

	assign pt_s  = $signed({{(DF-PT_TOL_W){1'b0}}, point_tol});
	assign ab_dx = DF'(x2) - DF'(x1);
	assign ab_dy = DF'(y2) - DF'(y1);
	assign bb_dx = DF'(x4) - DF'(x3);
	assign bb_dy = DF'(y4) - DF'(y3);
	assign q13x  = DF'(x1) - DF'(x3);
	assign q13y  = DF'(y1) - DF'(y3);
	assign q31x  = DF'(x3) - DF'(x1);
	assign q31y  = DF'(y3) - DF'(y1);
	assign a12x  = DF'(x1) - DF'(x2);
	assign a12y  = DF'(y1) - DF'(y2);
	assign b34x  = DF'(x3) - DF'(x4);
	assign b34y  = DF'(y3) - DF'(y4);

	always_ff @(posedge clk) begin
		if (en1) begin
			ab_dx_s1 <= ab_dx;
			ab_dy_s1 <= ab_dy;
			bb_dx_s1 <= bb_dx;
			bb_dy_s1 <= bb_dy;
			q13x_s1  <= q13x;
			q13y_s1  <= q13y;
			q31x_s1  <= q31x;
			q31y_s1  <= q31y;
			a12x_s1  <= a12x;
			a12y_s1  <= a12y;
			b34x_s1  <= b34x;
			b34y_s1  <= b34y;
			x1_s1 <= x1; y1_s1 <= y1; x2_s1 <= x2; y2_s1 <= y2;
			x3_s1 <= x3; y3_s1 <= y3; x4_s1 <= x4; y4_s1 <= y4;
			apt_s1   <= a12x <= pt_s && a12x >= -pt_s && a12y <= pt_s && a12y >= -pt_s;
			bpt_s1   <= b34x <= pt_s && b34x >= -pt_s && b34y <= pt_s && b34y >= -pt_s;
			close_s1 <= q13x <= pt_s && q13x >= -pt_s && q13y <= pt_s && q13y >= -pt_s;
		end
	end

	// stage 2: products
	logic signed [PW-1:0] ca1_s2, ca2_s2, da1_s2, da2_s2, la1_s2, la2_s2;
	logic signed [PW-1:0] cb1_s2, cb2_s2, db1_s2, db2_s2, lb1_s2, lb2_s2;
	logic signed [PW-1:0] dn1_s2, dn2_s2, t1_s2, t2_s2, u1_s2, u2_s2;
	logic signed [CP-1:0] c11_s2, c12_s2, c21_s2, c22_s2;
	logic signed [DF-1:0] a12x_s2, a12y_s2, b34x_s2, b34y_s2;
	logic signed [C-1:0]  x1_s2, y1_s2, x3_s2, y3_s2;
	logic                 apt_s2, bpt_s2, close_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			ca1_s2 <= q13y_s1 * bb_dx_s1;
			ca2_s2 <= q13x_s1 * bb_dy_s1;
			da1_s2 <= q13x_s1 * bb_dx_s1;
			da2_s2 <= q13y_s1 * bb_dy_s1;
			la1_s2 <= bb_dx_s1 * bb_dx_s1;
			la2_s2 <= bb_dy_s1 * bb_dy_s1;
			cb1_s2 <= q31y_s1 * ab_dx_s1;
			cb2_s2 <= q31x_s1 * ab_dy_s1;
			db1_s2 <= q31x_s1 * ab_dx_s1;
			db2_s2 <= q31y_s1 * ab_dy_s1;
			lb1_s2 <= ab_dx_s1 * ab_dx_s1;
			lb2_s2 <= ab_dy_s1 * ab_dy_s1;
			dn1_s2 <= a12x_s1 * b34y_s1;
			dn2_s2 <= a12y_s1 * b34x_s1;
			t1_s2  <= q13x_s1 * b34y_s1;
			t2_s2  <= q13y_s1 * b34x_s1;
			u1_s2  <= q13x_s1 * a12y_s1;
			u2_s2  <= q13y_s1 * a12x_s1;
			c11_s2 <= x1_s1 * y2_s1;
			c12_s2 <= y1_s1 * x2_s1;
			c21_s2 <= x3_s1 * y4_s1;
			c22_s2 <= y3_s1 * x4_s1;
			a12x_s2 <= a12x_s1;
			a12y_s2 <= a12y_s1;
			b34x_s2 <= b34x_s1;
			b34y_s2 <= b34y_s1;
			x1_s2 <= x1_s1; y1_s2 <= y1_s1; x3_s2 <= x3_s1; y3_s2 <= y3_s1;
			apt_s2 <= apt_s1;
			bpt_s2 <= bpt_s1;
			close_s2 <= close_s1;
		end
	end

	// stage 3: sums
	logic signed [SW-1:0] cra_s3, dta_s3, lna_s3, crb_s3, dtb_s3, lnb_s3;
	logic signed [SW-1:0] den_s3, tn_s3, un_s3;
	logic signed [CS-1:0] c1_s3, c2_s3;
	logic signed [DF-1:0] a12x_s3, a12y_s3, b34x_s3, b34y_s3;
	logic signed [C-1:0]  x1_s3, y1_s3, x3_s3, y3_s3;
	logic                 apt_s3, bpt_s3, close_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			cra_s3 <= SW'(ca1_s2) - SW'(ca2_s2);
			dta_s3 <= SW'(da1_s2) + SW'(da2_s2);
			lna_s3 <= SW'(la1_s2) + SW'(la2_s2);
			crb_s3 <= SW'(cb1_s2) - SW'(cb2_s2);
			dtb_s3 <= SW'(db1_s2) + SW'(db2_s2);
			lnb_s3 <= SW'(lb1_s2) + SW'(lb2_s2);
			den_s3 <= SW'(dn1_s2) - SW'(dn2_s2);
			tn_s3  <= SW'(t1_s2) - SW'(t2_s2);
			un_s3  <= SW'(u1_s2) - SW'(u2_s2);
			c1_s3  <= CS'(c11_s2) - CS'(c12_s2);
			c2_s3  <= CS'(c21_s2) - CS'(c22_s2);
			a12x_s3 <= a12x_s2;
			a12y_s3 <= a12y_s2;
			b34x_s3 <= b34x_s2;
			b34y_s3 <= b34y_s2;
			x1_s3 <= x1_s2; y1_s3 <= y1_s2; x3_s3 <= x3_s2; y3_s3 <= y3_s2;
			apt_s3 <= apt_s2;
			bpt_s3 <= bpt_s2;
			close_s3 <= close_s2;
		end
	end

	// stage 4: classify and form numerator products
	logic signed [SW-1:0] tol_s, den_a, tn_n, un_n;
	logic                 on_a, on_b, den_neg, cross_ok;
	hit_kind_t            kind;

	assign tol_s   = $signed({{(SW-COL_TOL_W){1'b0}}, col_tol});
	assign on_a    = cra_s3 <= tol_s && cra_s3 >= -tol_s && !dta_s3[SW-1] && dta_s3 <= lna_s3;
	assign on_b    = crb_s3 <= tol_s && crb_s3 >= -tol_s && !dtb_s3[SW-1] && dtb_s3 <= lnb_s3;
	assign den_neg = den_s3[SW-1];
	assign den_a   = den_neg ? -den_s3 : den_s3;
	assign tn_n    = den_neg ? -tn_s3 : tn_s3;
	assign un_n    = den_neg ? -un_s3 : un_s3;
	assign cross_ok = den_s3 != '0 && !tn_n[SW-1] && tn_n <= den_a
		&& !un_n[SW-1] && un_n <= den_a;

	always_comb begin
		priority if (apt_s3 && bpt_s3) kind = close_s3 ? KIND_A_PT : KIND_NONE;
		else if (apt_s3 && on_a)       kind = KIND_A_PT;
		else if (bpt_s3)               kind = on_b ? KIND_B_PT : KIND_NONE;
		else                           kind = cross_ok ? KIND_CROSS : KIND_NONE;
	end

	logic signed [NP-1:0] nx1_s4, nx2_s4, ny1_s4, ny2_s4;
	logic [DW-1:0]        den_s4;
	logic                 den_neg_s4;
	hit_kind_t            kind_s4;
	logic signed [C-1:0]  px_s4, py_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			nx1_s4     <= c1_s3 * b34x_s3;
			nx2_s4     <= a12x_s3 * c2_s3;
			ny1_s4     <= c1_s3 * b34y_s3;
			ny2_s4     <= a12y_s3 * c2_s3;
			den_s4     <= den_a[DW-1:0];
			den_neg_s4 <= den_neg;
			kind_s4    <= kind;
			px_s4      <= (kind == KIND_B_PT) ? x3_s3 : x1_s3;
			py_s4      <= (kind == KIND_B_PT) ? y3_s3 : y1_s3;
		end
	end

	// stage 5: numerators, sign-normalized, split into sign and magnitude
	logic signed [NW-1:0] nx, ny;
	logic                 sx, sy;

	assign nx = den_neg_s4 ? (NW'(nx2_s4) - NW'(nx1_s4)) : (NW'(nx1_s4) - NW'(nx2_s4));
	assign ny = den_neg_s4 ? (NW'(ny2_s4) - NW'(ny1_s4)) : (NW'(ny1_s4) - NW'(ny2_s4));
	assign sx = nx[NW-1];
	assign sy = ny[NW-1];

	always_ff @(posedge clk) begin
		if (en5) begin
			dn_nx   <= sx ? -nx : nx;
			dn_ny   <= sy ? -ny : ny;
			dn_negx <= sx;
			dn_negy <= sy;
			dn_den  <= den_s4;
			dn_kind <= kind_s4;
			dn_px   <= px_s4;
			dn_py   <= py_s4;
		end
	end

	assign dn_valid = v_s5;
endmodule

// File: hw/rtl/sip_div.sv
// Pipelined restoring divider, one quotient bit per stage, x and y in parallel.
// Result stage drives the output channel; depends on sip_pkg.
module sip_div
	import sip_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  hit_kind_t                     up_kind,
	input  logic signed [COORD_BITS-1:0]  up_px,
	input  logic signed [COORD_BITS-1:0]  up_py,
	input  logic [2*COORD_BITS+1:0]       up_den,
	input  logic [3*COORD_BITS+2:0]       up_nx,
	input  logic [3*COORD_BITS+2:0]       up_ny,
	input  logic                          up_negx,
	input  logic                          up_negy,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit,
	output logic [1:0]                    hit_kind,
	output logic signed [COORD_BITS-1:0]  hit_x,
	output logic signed [COORD_BITS-1:0]  hit_y
);
	localparam int C  = COORD_BITS;
	localparam int NW = 3 * C + 3;
	localparam int DW = 2 * C + 2;

	logic                v_s  [C];
	logic [C:0]          en;
	logic [NW-1:0]       rx_s [C];
	logic [NW-1:0]       ry_s [C];
	logic [C-1:0]        qx_s [C];
	logic [C-1:0]        qy_s [C];
	logic [DW-1:0]       den_s [C];
	hit_kind_t           kind_s [C];
	logic signed [C-1:0] px_s [C];
	logic signed [C-1:0] py_s [C];
	logic                negx_s [C];
	logic                negy_s [C];

	assign en[C]    = out_ready;
	assign up_ready = en[0];

	for (genvar k = 0; k < C; k++) begin : g_stage
		localparam int I = C - 1 - k;
		logic [NW-1:0]       rx_in, ry_in, dsh;
		logic [C-1:0]        qx_in, qy_in;
		logic [DW-1:0]       den_in;
		logic                v_in;
		logic [NW:0]         tx, ty;
		hit_kind_t           kind_in;
		logic signed [C-1:0] px_in, py_in;
		logic                negx_in, negy_in;

		if (k == 0) begin : g_first
			assign rx_in   = up_nx;
			assign ry_in   = up_ny;
			assign qx_in   = '0;
			assign qy_in   = '0;
			assign den_in  = up_den;
			assign v_in    = up_valid;
			assign kind_in = up_kind;
			assign px_in   = up_px;
			assign py_in   = up_py;
			assign negx_in = up_negx;
			assign negy_in = up_negy;
		end else begin : g_next
			assign rx_in   = rx_s[k-1];
			assign ry_in   = ry_s[k-1];
			assign qx_in   = qx_s[k-1];
			assign qy_in   = qy_s[k-1];
			assign den_in  = den_s[k-1];
			assign v_in    = v_s[k-1];
			assign kind_in = kind_s[k-1];
			assign px_in   = px_s[k-1];
			assign py_in   = py_s[k-1];
			assign negx_in = negx_s[k-1];
			assign negy_in = negy_s[k-1];
		end

		assign en[k] = !v_s[k] || en[k+1];
		assign dsh   = {{(NW-DW){1'b0}}, den_in} << I;
		assign tx    = {1'b0, rx_in} - {1'b0, dsh};
		assign ty    = {1'b0, ry_in} - {1'b0, dsh};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rx_s[k]   <= tx[NW] ? rx_in : tx[NW-1:0];
				ry_s[k]   <= ty[NW] ? ry_in : ty[NW-1:0];
				qx_s[k]   <= qx_in | (C'(!tx[NW]) << I);
				qy_s[k]   <= qy_in | (C'(!ty[NW]) << I);
				den_s[k]  <= den_in;
				kind_s[k] <= kind_in;
				px_s[k]   <= px_in;
				py_s[k]   <= py_in;
				negx_s[k] <= negx_in;
				negy_s[k] <= negy_in;
			end
		end
	end

	logic [C-1:0] qx, qy;

	assign qx        = negx_s[C-1] ? -qx_s[C-1] : qx_s[C-1];
	assign qy        = negy_s[C-1] ? -qy_s[C-1] : qy_s[C-1];
	assign out_valid = v_s[C-1];
	assign hit       = kind_s[C-1] != KIND_NONE;
	assign hit_kind  = kind_s[C-1];

	always_comb begin
		unique case (kind_s[C-1])
			KIND_CROSS: begin
				hit_x = $signed(qx);
				hit_y = $signed(qy);
			end
			KIND_A_PT, KIND_B_PT: begin
				hit_x = px_s[C-1];
				hit_y = py_s[C-1];
			end
			default: begin
				hit_x = '0;
				hit_y = '0;
			end
		endcase
	end
endmodule

// File: hw/rtl/segment_intersection_point.sv
// Two-segment intersection test with intersection point, Q11.4 coordinates.
// A new segment pair is taken every clock cycle unless output stalls have filled
// the pipeline; each transaction passes COORD_BITS + 5 register stages, five
// arithmetic stages followed by one divider stage per quotient bit. Stalls on
// the output hold the pipeline without loss, and bubbles in the pipeline still
// absorb new transactions. Write point_tolerance (index 0) and
// collinear_tolerance (index 1) only while no transaction is in flight.
// Depends on sip_pkg, sip_in_if, sip_out_if, sip_front and sip_div.
module segment_intersection_point
	import sip_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	sip_in_if.sink                 in_ch,
	sip_out_if.source              out_ch
);
	localparam int C = COORD_BITS;

	logic [PT_TOL_W-1:0]  point_tol_q;
	logic [COL_TOL_W-1:0] col_tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_tol_q <= '0;
			col_tol_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POINT_TOL: point_tol_q <= cfg_wdata[PT_TOL_W-1:0];
				REG_COL_TOL:   col_tol_q   <= cfg_wdata[COL_TOL_W-1:0];
				default: ;
			endcase
		end
	end

	logic               f_valid, f_ready, f_negx, f_negy;
	hit_kind_t          f_kind;
	logic signed [C-1:0] f_px, f_py;
	logic [2*C+1:0]     f_den;
	logic [3*C+2:0]     f_nx, f_ny;

	sip_front #(.COORD_BITS(C)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.point_tol(point_tol_q),
		.col_tol  (col_tol_q),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.x1       (in_ch.a_start_x),
		.y1       (in_ch.a_start_y),
		.x2       (in_ch.a_end_x),
		.y2       (in_ch.a_end_y),
		.x3       (in_ch.b_start_x),
		.y3       (in_ch.b_start_y),
		.x4       (in_ch.b_end_x),
		.y4       (in_ch.b_end_y),
		.dn_valid (f_valid),
		.dn_ready (f_ready),
		.dn_kind  (f_kind),
		.dn_px    (f_px),
		.dn_py    (f_py),
		.dn_den   (f_den),
		.dn_nx    (f_nx),
		.dn_ny    (f_ny),
		.dn_negx  (f_negx),
		.dn_negy  (f_negy)
	);

	sip_div #(.COORD_BITS(C)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (f_valid),
		.up_ready (f_ready),
		.up_kind  (f_kind),
		.up_px    (f_px),
		.up_py    (f_py),
		.up_den   (f_den),
		.up_nx    (f_nx),
		.up_ny    (f_ny),
		.up_negx  (f_negx),
		.up_negy  (f_negy),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.hit      (out_ch.hit),
		.hit_kind (out_ch.hit_kind),
		.hit_x    (out_ch.hit_x),
		.hit_y    (out_ch.hit_y)
	);
endmodule
